>>> rtl/core/snapshot_record_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the snapshot record parser core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_RECORD_PARSER_CORE_ASSERT_SVH
`define SNAPSHOT_RECORD_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRP_ASSERT(lbl, prop, msg)
`define SRP_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/srp_pkg.sv
// ----------------------------------------------------------------------------
// Snapshot record parser package
// Item types, event and error codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELECT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING = 8'd3;

    localparam logic [63:0] MAGIC_RESET  = 64'h4D49_4E52_4544_4953;
    localparam logic [7:0]  SELECT_RESET = 8'hFE;
    localparam logic [7:0]  END_RESET    = 8'hFF;
    localparam logic [7:0]  STRING_RESET = 8'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_SELECT  = 3'd1;
    localparam logic [2:0] EV_KEYLEN  = 3'd2;
    localparam logic [2:0] EV_KEYBYTE = 3'd3;
    localparam logic [2:0] EV_VALLEN  = 3'd4;
    localparam logic [2:0] EV_VALBYTE = 3'd5;
    localparam logic [2:0] EV_DONE    = 3'd6;
    localparam logic [2:0] EV_ERROR   = 3'd7;

    localparam logic [2:0] ERR_SHORT_HEADER = 3'd0;
    localparam logic [2:0] ERR_MAGIC        = 3'd1;
    localparam logic [2:0] ERR_NO_OPCODE    = 3'd2;
    localparam logic [2:0] ERR_NO_DATABASE  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [31:0] entry_length;
        logic [7:0]  database_number;
        logic        last_byte;
        logic [2:0]  error_code;
    } evt_item_t;

    typedef struct packed {
        logic [7:0] select_code;
        logic [7:0] end_code;
        logic [7:0] string_code;
    } opcode_cfg_t;

    typedef struct packed {
        logic       eos;
        logic [7:0] data_byte;
        logic       is_end;
        logic       is_select;
        logic       is_string;
    } q_item_t;

endpackage

`default_nettype wire

>>> rtl/core/srp_front.sv
// ----------------------------------------------------------------------------
// Snapshot record parser front end
// Accepts request bytes and tags each with its opcode class for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_front (
    input  wire                  req_valid,
    output logic                 req_stall,
    input  srp_pkg::req_item_t   req_item,
    input  srp_pkg::opcode_cfg_t codes,
    input  wire                  q_full,
    output logic                 q_push,
    output srp_pkg::q_item_t     q_item
);
    import srp_pkg::*;

    logic hit_end;
    logic hit_select;
    logic hit_string;

    assign hit_end    = req_item.data_byte == codes.end_code;
    assign hit_select = req_item.data_byte == codes.select_code;
    assign hit_string = req_item.data_byte == codes.string_code;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        q_item.eos       = req_item.action;
        q_item.data_byte = req_item.data_byte;
        q_item.is_end    = hit_end;
        q_item.is_select = hit_select && !hit_end;
        q_item.is_string = hit_string && !hit_select && !hit_end;
    end

endmodule

`default_nettype wire

>>> rtl/core/srp_queue.sv
// ----------------------------------------------------------------------------
// Snapshot record parser queue
// Short FIFO of classified bytes between the front end and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "snapshot_record_parser_core_assert.svh"

module srp_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  srp_pkg::q_item_t push_item,
    output logic             full,
    input  wire              pop,
    output logic             q_valid,
    output srp_pkg::q_item_t head_item
);
    import srp_pkg::*;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    q_item_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = count_reg == CNT_FULL;
    assign q_valid   = count_reg != '0;
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SRP_NEVER(a_count_bound, count_reg > CNT_FULL, "queue count beyond depth")
    `SRP_ASSERT(a_push_fills, do_push |=> count_reg != '0, "push left queue empty")
    `SRP_ASSERT(a_pop_drains, do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1, "pop did not lower count")

endmodule

`default_nettype wire

>>> rtl/core/srp_back.sv
// ----------------------------------------------------------------------------
// Snapshot record parser back end
// Runs the dump grammar on queued bytes and registers the resulting events.
// ----------------------------------------------------------------------------
`default_nettype none

`include "snapshot_record_parser_core_assert.svh"

module srp_back #(
    parameter int MAGIC_BYTES  = 8,
    parameter int LENGTH_BYTES = 4
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                q_valid,
    input  srp_pkg::q_item_t   head_item,
    output logic               pop,
    input  wire  [63:0]        magic_word,
    output logic               evt_valid,
    input  wire                evt_stall,
    output srp_pkg::evt_item_t evt_item
);
    import srp_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_OPCODE,
        PH_SELECT,
        PH_KEYLEN,
        PH_KEYDATA,
        PH_VALLEN,
        PH_VALDATA,
        PH_HALT
    } phase_t;

    localparam logic [2:0] MAGIC_LAST = 3'(MAGIC_BYTES - 1);
    localparam logic [2:0] LEN_LAST   = 3'(LENGTH_BYTES - 1);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  byte_index_reg;
    logic [2:0]  byte_index_next;
    logic [31:0] length_acc_reg;
    logic [31:0] length_acc_next;
    logic [31:0] remaining_reg;
    logic [31:0] remaining_next;
    logic [7:0]  database_reg;
    logic [7:0]  database_next;
    logic        evt_valid_reg;
    logic        evt_valid_next;
    evt_item_t   evt_item_reg;
    evt_item_t   evt_item_next;

    logic        emit;
    evt_item_t   emit_item;
    logic [2:0]  magic_sel;
    logic [7:0]  magic_want;
    logic [31:0] length_shift;
    logic        data_last;
    logic [7:0]  b;

    assign pop          = q_valid && (!evt_valid_reg || !evt_stall);
    assign b            = head_item.data_byte;
    assign magic_sel    = MAGIC_LAST - byte_index_reg;
    assign magic_want   = magic_word[{magic_sel, 3'b000} +: 8];
    assign length_shift = {length_acc_reg[23:0], b};
    assign data_last    = remaining_reg <= 32'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        length_acc_next = length_acc_reg;
        remaining_next  = remaining_reg;
        database_next   = database_reg;
        emit            = 1'b0;
        emit_item       = '0;

        if (pop)
        begin
            if (head_item.eos)
            begin
                phase_next          = PH_MAGIC;
                byte_index_next     = '0;
                length_acc_next     = '0;
                remaining_next      = '0;
                database_next       = '0;
                emit                = phase_reg != PH_HALT;
                emit_item.event_res = EV_ERROR;
                case (phase_reg)
                    PH_MAGIC, PH_VERSION: emit_item.error_code = ERR_SHORT_HEADER;
                    PH_OPCODE:            emit_item.error_code = ERR_NO_OPCODE;
                    PH_SELECT:            emit_item.error_code = ERR_NO_DATABASE;
                    PH_KEYLEN, PH_KEYDATA, PH_VALLEN, PH_VALDATA:
                                          emit_item.error_code = ERR_TRUNCATED;
                    default:              emit_item.error_code = ERR_SHORT_HEADER;
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (b != magic_want)
                        begin
                            phase_next           = PH_HALT;
                            emit                 = 1'b1;
                            emit_item.event_res  = EV_ERROR;
                            emit_item.error_code = ERR_MAGIC;
                        end
                        else if (byte_index_reg == MAGIC_LAST)
                        begin
                            byte_index_next = '0;
                            phase_next      = PH_VERSION;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 1'b1;
                        end
                    end
                    PH_VERSION:
                    begin
                        phase_next             = PH_OPCODE;
                        emit                   = 1'b1;
                        emit_item.event_res    = EV_HEADER;
                        emit_item.payload_byte = b;
                    end
                    PH_OPCODE:
                    begin
                        if (head_item.is_end)
                        begin
                            phase_next          = PH_HALT;
                            emit                = 1'b1;
                            emit_item.event_res = EV_DONE;
                        end
                        else if (head_item.is_select)
                        begin
                            phase_next = PH_SELECT;
                        end
                        else if (head_item.is_string)
                        begin
                            phase_next      = PH_KEYLEN;
                            byte_index_next = '0;
                            length_acc_next = '0;
                        end
                    end
                    PH_SELECT:
                    begin
                        database_next          = b;
                        phase_next             = PH_OPCODE;
                        emit                   = 1'b1;
                        emit_item.event_res    = EV_SELECT;
                        emit_item.payload_byte = b;
                    end
                    PH_KEYLEN, PH_VALLEN:
                    begin
                        if (byte_index_reg != LEN_LAST)
                        begin
                            length_acc_next = length_shift;
                            byte_index_next = byte_index_reg + 1'b1;
                        end
                        else
                        begin
                            byte_index_next        = '0;
                            length_acc_next        = '0;
                            remaining_next         = length_shift;
                            emit                   = 1'b1;
                            emit_item.entry_length = length_shift;
                            if (phase_reg == PH_KEYLEN)
                            begin
                                emit_item.event_res = EV_KEYLEN;
                                phase_next = (length_shift != '0) ? PH_KEYDATA : PH_VALLEN;
                            end
                            else
                            begin
                                emit_item.event_res = EV_VALLEN;
                                phase_next = (length_shift != '0) ? PH_VALDATA : PH_OPCODE;
                            end
                        end
                    end
                    PH_KEYDATA, PH_VALDATA:
                    begin
                        emit                   = 1'b1;
                        emit_item.payload_byte = b;
                        emit_item.last_byte    = data_last;
                        emit_item.event_res    = (phase_reg == PH_KEYDATA) ? EV_KEYBYTE
                                                                           : EV_VALBYTE;
                        if (data_last)
                        begin
                            remaining_next  = '0;
                            byte_index_next = '0;
                            length_acc_next = '0;
                            phase_next = (phase_reg == PH_KEYDATA) ? PH_VALLEN : PH_OPCODE;
                        end
                        else
                        begin
                            remaining_next = remaining_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
        emit_item.database_number = database_next;

        evt_valid_next = evt_valid_reg;
        evt_item_next  = evt_item_reg;
        if (emit)
        begin
            evt_valid_next = 1'b1;
            evt_item_next  = emit_item;
        end
        else if (evt_valid_reg && !evt_stall)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            byte_index_reg <= '0;
            length_acc_reg <= '0;
            remaining_reg  <= '0;
            database_reg   <= '0;
            evt_valid_reg  <= 1'b0;
            evt_item_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            length_acc_reg <= length_acc_next;
            remaining_reg  <= remaining_next;
            database_reg   <= database_next;
            evt_valid_reg  <= evt_valid_next;
            evt_item_reg   <= evt_item_next;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_item  = evt_item_reg;

    `SRP_ASSERT(a_err_code_clean,
        evt_valid_reg && evt_item_reg.event_res != EV_ERROR
            |-> evt_item_reg.error_code == ERR_SHORT_HEADER,
        "error code on non-error event")
    `SRP_ASSERT(a_data_has_bytes,
        phase_reg == PH_KEYDATA || phase_reg == PH_VALDATA |-> remaining_reg != '0,
        "data phase with no bytes left")
    `SRP_ASSERT(a_eos_rearms,
        pop && head_item.eos |=> phase_reg == PH_MAGIC && database_reg == '0,
        "end of stream did not re-arm")

endmodule

`default_nettype wire

>>> rtl/core/snapshot_record_parser_core.sv
// ----------------------------------------------------------------------------
// Snapshot record parser core
// Byte-serial parser for a key-value snapshot dump with configurable codes.
// ----------------------------------------------------------------------------
// Feed the dump on the request channel one byte per request: action 0 carries
// data_byte, action 1 marks end of stream. A request is taken at a clock edge
// with req_valid high and req_stall low.
// Events leave on the evt channel under the same valid and stall rules. A
// request that yields an event raises evt_valid once it has passed the queue
// and the output register; matching magic bytes, opcodes other than the end
// code and length bytes before the last give none. Throughput is one byte
// per cycle from a four-entry queue while the output register is free or
// not stalled. While evt_stall is high the event holds in the output
// register; the queue keeps taking bytes until it fills, then req_stall rises.
// Write cfg_index/cfg_data with cfg_valid while the parser is idle; cfg_ready
// is always high. Index 0 magic word, 1 select code, 2 end code, 3 string
// code; other indexes are ignored.
// Reset empties the queue, drops any pending event, loads the default codes
// and arms the header check. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module snapshot_record_parser_core #(
    parameter int MAGIC_BYTES  = 8,
    parameter int LENGTH_BYTES = 4
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    output logic                               req_stall,
    input  srp_pkg::req_item_t                 req_item,
    output logic                               evt_valid,
    input  wire                                evt_stall,
    output srp_pkg::evt_item_t                 evt_item,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [srp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [srp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import srp_pkg::*;

    logic [63:0] magic_reg;
    opcode_cfg_t codes_reg;
    logic        q_full;
    logic        q_push;
    q_item_t     q_push_item;
    logic        q_pop;
    logic        q_valid;
    q_item_t     q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg             <= MAGIC_RESET;
            codes_reg.select_code <= SELECT_RESET;
            codes_reg.end_code    <= END_RESET;
            codes_reg.string_code <= STRING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC:  magic_reg             <= cfg_data;
                CFG_SELECT: codes_reg.select_code <= cfg_data[7:0];
                CFG_END:    codes_reg.end_code    <= cfg_data[7:0];
                CFG_STRING: codes_reg.string_code <= cfg_data[7:0];
                default:    magic_reg             <= magic_reg;
            endcase
        end
    end

    srp_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .codes     (codes_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    srp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_item (q_head)
    );

    srp_back #(
        .MAGIC_BYTES  (MAGIC_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_item  (q_head),
        .pop        (q_pop),
        .magic_word (magic_reg),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_item   (evt_item)
    );

endmodule

`default_nettype wire
